@@ src/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg - shared types, constants and functions of the oscillator core
// Word widths, register indexes, reset values, the state type, saturation
// and the cosine table generator.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF       = 24;
    localparam int COS_TABLE_BITS_DEF  = 10;
    localparam int STEP_COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int WORD_W     = 32;
    localparam int COEF_W     = 31;
    localparam int PHASE_W    = 32;
    localparam int TOTAL_W    = 16;
    localparam int MUL_DIGIT  = 4;
    localparam int SAT_IN_W   = 64;

    // stream and configuration port widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 3 * WORD_W;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_TWICE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TOTAL    = 3'd4;

    // register reset values
    localparam logic [COEF_W-1:0]  RST_TIME_STEP     = 31'd316247;
    localparam logic [COEF_W-1:0]  RST_STIFFNESS     = 31'd16777216;
    localparam logic [COEF_W-1:0]  RST_DAMPING_TWICE = 31'd8388608;
    localparam logic [PHASE_W-1:0] RST_PHASE_STEP    = 32'd0;
    localparam logic [TOTAL_W-1:0] RST_STEP_TOTAL    = 16'd1000;

    // cosine table generator constants (Q2.30 angle, Q30 values)
    localparam longint PIHALF_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30    = 64'sd1073741824;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_ACC1,
        S_ACC2,
        S_START2,
        S_MUL2,
        S_UPD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mul_start;
        logic mul_sel2;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic                     clip;
        logic signed [WORD_W-1:0] val;
    } t_sat;

    // clip a wide signed value into one signed word
    function automatic t_sat sat_word(input logic signed [SAT_IN_W-1:0] v);
        t_sat r;
        if (v[SAT_IN_W-1:WORD_W-1] == '0 || v[SAT_IN_W-1:WORD_W-1] == '1) begin
            r.clip = 1'b0;
            r.val  = v[WORD_W-1:0];
        end else begin
            r.clip = 1'b1;
            r.val  = v[SAT_IN_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                   : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    // one quarter-wave entry: Horner series of cos in Q30, rounded to frac_bits
    function automatic longint cos_entry(input int idx, input int frac_bits,
                                         input int tab_bits);
        longint a;
        longint a2;
        longint t;
        longint r;
        a  = (PIHALF_Q30 * longint'(idx)) >>> tab_bits;
        a2 = (a * a) >>> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 240;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 182;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 132;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 90;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 56;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 30;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 12;
        t  = ONE_Q30 - ((a2 * t) >>> 30) / 2;
        r  = (t + ((longint'(1) <<< (30 - frac_bits)) >>> 1)) >>> (30 - frac_bits);
        if (r < 0) begin
            r = 0;
        end
        if (r > (longint'(1) <<< frac_bits)) begin
            r = longint'(1) <<< frac_bits;
        end
        return r;
    endfunction

endpackage

@@ src/ddo_smul.sv @@
// ----------------------------------------------------------------------------
// ddo_smul - digit-serial signed by unsigned multiplier
// Consumes the unsigned operand one digit per cycle, low digit first; the
// partial sum shifts right so the adder stays one word plus one digit wide.
// ----------------------------------------------------------------------------
module ddo_smul
    import ddo_pkg::*;
#(
    parameter int A_W   = WORD_W,
    parameter int B_W   = COEF_W,
    parameter int DIGIT = MUL_DIGIT
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic signed [A_W-1:0]                                 i_a,
    input  logic        [B_W-1:0]                                 i_b,
    output logic signed [A_W+((B_W+DIGIT-1)/DIGIT)*DIGIT-1:0]     o_prod,
    output logic                                                  o_done
);

    localparam int N_DIG = (B_W + DIGIT - 1) / DIGIT;
    localparam int LO_W  = N_DIG * DIGIT;
    localparam int SUM_W = A_W + DIGIT;
    localparam int CNT_W = $clog2(N_DIG + 1);

    logic signed [A_W-1:0]   r_a;
    logic        [LO_W-1:0]  r_b;
    logic signed [A_W-1:0]   r_hi;
    logic        [LO_W-1:0]  r_lo;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_done;

    logic signed [SUM_W-1:0] w_a_ext;
    logic signed [SUM_W-1:0] w_d_ext;
    logic signed [SUM_W-1:0] w_pp;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_busy;

    assign w_busy  = (r_cnt != '0);
    assign w_a_ext = SUM_W'(r_a);
    assign w_d_ext = $signed(SUM_W'(r_b[DIGIT-1:0]));
    assign w_pp    = w_a_ext * w_d_ext;
    assign w_sum   = SUM_W'(r_hi) + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(N_DIG);
            r_done <= 1'b0;
        end else if (w_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= LO_W'(i_b);
            r_hi <= '0;
        end else if (w_busy) begin
            // retire one digit: low bits of the sum leave into the low half
            r_hi <= w_sum[SUM_W-1:DIGIT];
            r_lo <= {w_sum[DIGIT-1:0], r_lo[LO_W-1:DIGIT]};
            r_b  <= r_b >> DIGIT;
        end
    end

    assign o_prod = $signed({r_hi, r_lo});
    assign o_done = r_done;

endmodule

@@ src/ddo_cos.sv @@
// ----------------------------------------------------------------------------
// ddo_cos - drive cosine from a quarter-wave table
// Folds the phase into the first quadrant, reads the table into a register,
// then applies the quadrant sign into the output register.
// ----------------------------------------------------------------------------
module ddo_cos
    import ddo_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic        [PHASE_W-1:0]   i_phase,
    output logic signed [FRAC_BITS+1:0] o_cos
);

    localparam int COS_Q = 1 << COS_TABLE_BITS;
    localparam int ADR_W = COS_TABLE_BITS + 1;

    logic [FRAC_BITS:0] w_rom [0:COS_Q];

    for (genvar gi = 0; gi <= COS_Q; gi++) begin : g_rom
        localparam longint Val = cos_entry(gi, FRAC_BITS, COS_TABLE_BITS);
        assign w_rom[gi] = Val[FRAC_BITS:0];
    end

    logic [1:0]                  w_quad;
    logic [COS_TABLE_BITS-1:0]   w_j;
    logic [ADR_W-1:0]            w_addr;
    logic [FRAC_BITS:0]          r_rd;
    logic                        r_neg;
    logic signed [FRAC_BITS+1:0] w_mag;
    logic signed [FRAC_BITS+1:0] r_cos;

    assign w_quad = i_phase[PHASE_W-1 -: 2];
    assign w_j    = i_phase[PHASE_W-3 -: COS_TABLE_BITS];
    // odd quadrants read the table backward from the top entry
    assign w_addr = w_quad[0] ? (ADR_W'(COS_Q) - ADR_W'(w_j)) : ADR_W'(w_j);
    assign w_mag  = $signed({1'b0, r_rd});

    always_ff @(posedge i_clk) begin
        r_rd  <= w_rom[w_addr];
        r_neg <= w_quad[0] ^ w_quad[1];
        r_cos <= r_neg ? -w_mag : w_mag;
    end

    assign o_cos = r_cos;

endmodule

@@ src/driven_damped_oscillator_euler_core.sv @@
// ----------------------------------------------------------------------------
// driven_damped_oscillator_euler_core - forward Euler step of a driven,
// damped oscillator in signed fixed point
//
//   channel  direction  handshake                  payload
//   s_axis   in         tvalid/tready              tdata[0] restart
//   m_axis   out        tvalid/tready              tdata time/pos/vel, tlast,
//                                                  tuser saturated/done_res
//   cfg      in         wr_en (no wait)            index, data
//
// A step request runs two passes of the 4-bit digit-serial multiplier pair;
// restart and done-report requests skip the multipliers and go straight to
// the emit state.
// Reset clears the state, the counter and the configuration registers to their defaults.
// A new request is taken while a result still waits in the output register;
// a stalled output holds the core in its emit state.
// ----------------------------------------------------------------------------
module driven_damped_oscillator_euler_core
    import ddo_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int COS_TABLE_BITS  = COS_TABLE_BITS_DEF,
    parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [0] restart, rest zero
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] time_now,
                                                    // [63:32] position,
                                                    // [95:64] velocity
    output logic                  o_m_axis_tlast,   // last
    output logic [OUT_USER_W-1:0] o_m_axis_tuser    // [0] saturated, [1] done_res
);

    localparam int N_DIG = (COEF_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int P_W   = WORD_W + N_DIG * MUL_DIGIT;
    localparam int SH_W  = P_W - FRAC_BITS;
    localparam int S1_W  = SH_W + 1;
    localparam int CMP_W = (STEP_COUNT_BITS > TOTAL_W) ? STEP_COUNT_BITS : TOTAL_W;

    // configuration registers
    logic [COEF_W-1:0]  r_time_step;
    logic [COEF_W-1:0]  r_stiffness;
    logic [COEF_W-1:0]  r_damping_twice;
    logic [PHASE_W-1:0] r_phase_step;
    logic [TOTAL_W-1:0] r_step_total;

    // oscillator state
    logic signed [WORD_W-1:0]  r_pos;
    logic signed [WORD_W-1:0]  r_vel;
    logic signed [WORD_W-1:0]  r_time;
    logic [PHASE_W-1:0]        r_phase;
    logic [STEP_COUNT_BITS-1:0] r_count;
    logic                      r_sat;
    logic                      r_done_item;

    // step temporaries
    logic signed [S1_W-1:0]   r_s1;
    logic signed [WORD_W-1:0] r_acc;

    // output register
    logic                     r_m_valid;
    logic signed [WORD_W-1:0] r_m_time;
    logic signed [WORD_W-1:0] r_m_pos;
    logic signed [WORD_W-1:0] r_m_vel;
    logic                     r_m_sat;
    logic                     r_m_last;
    logic                     r_m_done;

    t_state r_state;
    t_state n_state;
    t_ctl   w_ctl;

    logic                        w_in_acc;
    logic                        w_restart;
    logic                        w_run_done;
    logic signed [WORD_W-1:0]    w_a0;
    logic        [COEF_W-1:0]    w_b0;
    logic        [COEF_W-1:0]    w_b1;
    logic signed [P_W-1:0]       w_prod0;
    logic signed [P_W-1:0]       w_prod1;
    logic                        w_done0;
    logic                        w_done1;
    logic signed [SH_W-1:0]      w_sh0;
    logic signed [SH_W-1:0]      w_sh1;
    logic signed [FRAC_BITS+1:0] w_cos;
    logic signed [S1_W-1:0]      w_s1;
    t_sat                        w_acc_sat;
    t_sat                        w_pos_sat;
    t_sat                        w_vel_sat;
    t_sat                        w_time_sat;

    assign w_in_acc   = i_s_axis_tvalid && w_ctl.in_ready;
    assign w_restart  = i_s_axis_tdata[0];
    assign w_run_done = (CMP_W'(r_count) >= CMP_W'(r_step_total));

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step     <= RST_TIME_STEP;
            r_stiffness     <= RST_STIFFNESS;
            r_damping_twice <= RST_DAMPING_TWICE;
            r_phase_step    <= RST_PHASE_STEP;
            r_step_total    <= RST_STEP_TOTAL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TIME_STEP:     r_time_step     <= i_cfg_data[COEF_W-1:0];
                REG_STIFFNESS:     r_stiffness     <= i_cfg_data[COEF_W-1:0];
                REG_DAMPING_TWICE: r_damping_twice <= i_cfg_data[COEF_W-1:0];
                REG_PHASE_STEP:    r_phase_step    <= i_cfg_data[PHASE_W-1:0];
                REG_STEP_TOTAL:    r_step_total    <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_restart || w_run_done) ? S_EMIT : S_MUL1;
                end
            end
            S_MUL1: begin
                if (w_done0) begin
                    n_state = S_ACC1;
                end
            end
            S_ACC1:   n_state = S_ACC2;
            S_ACC2:   n_state = S_START2;
            S_START2: n_state = S_MUL2;
            S_MUL2: begin
                if (w_done0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:    n_state = S_EMIT;
            S_EMIT: begin
                if (w_ctl.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            S_IDLE: begin
                w_ctl.in_ready  = 1'b1;
                w_ctl.mul_start = i_s_axis_tvalid && !w_restart && !w_run_done;
            end
            S_START2: begin
                w_ctl.mul_start = 1'b1;
                w_ctl.mul_sel2  = 1'b1;
            end
            S_EMIT: begin
                w_ctl.out_load = !r_m_valid || i_m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // multipliers and cosine
    // first pass: k*x and c*v; second pass: acc*dt and v*dt
    // ------------------------------------------------------------------
    assign w_a0 = w_ctl.mul_sel2 ? r_acc : r_pos;
    assign w_b0 = w_ctl.mul_sel2 ? r_time_step : r_stiffness;
    assign w_b1 = w_ctl.mul_sel2 ? r_time_step : r_damping_twice;

    ddo_smul #(
        .A_W   (WORD_W),
        .B_W   (COEF_W),
        .DIGIT (MUL_DIGIT)
    ) u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.mul_start),
        .i_a     (w_a0),
        .i_b     (w_b0),
        .o_prod  (w_prod0),
        .o_done  (w_done0)
    );

    ddo_smul #(
        .A_W   (WORD_W),
        .B_W   (COEF_W),
        .DIGIT (MUL_DIGIT)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.mul_start),
        .i_a     (r_vel),
        .i_b     (w_b1),
        .o_prod  (w_prod1),
        .o_done  (w_done1)
    );

    ddo_cos #(
        .FRAC_BITS      (FRAC_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos (
        .i_clk   (i_clk),
        .i_phase (r_phase),
        .o_cos   (w_cos)
    );

    // drop the fraction bits: arithmetic shift rounds toward minus infinity
    assign w_sh0 = $signed(w_prod0[P_W-1:FRAC_BITS]);
    assign w_sh1 = $signed(w_prod1[P_W-1:FRAC_BITS]);

    assign w_s1       = S1_W'(w_cos) - S1_W'(w_sh0);
    assign w_acc_sat  = sat_word(SAT_IN_W'(r_s1) - SAT_IN_W'(w_sh1));
    assign w_pos_sat  = sat_word(SAT_IN_W'(r_pos) + SAT_IN_W'(w_sh1));
    assign w_vel_sat  = sat_word(SAT_IN_W'(r_vel) + SAT_IN_W'(w_sh0));
    assign w_time_sat = sat_word(SAT_IN_W'(r_time) + $signed(SAT_IN_W'(r_time_step)));

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC1) begin
            r_s1 <= w_s1;
        end
        if (r_state == S_ACC2) begin
            r_acc <= w_acc_sat.val;
        end
    end

    // ------------------------------------------------------------------
    // oscillator state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_vel       <= '0;
            r_time      <= '0;
            r_phase     <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_done_item <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sat       <= 1'b0;
                        r_done_item <= !w_restart && w_run_done;
                        if (w_restart) begin
                            r_pos   <= '0;
                            r_vel   <= '0;
                            r_time  <= '0;
                            r_phase <= '0;
                            r_count <= '0;
                        end
                    end
                end
                S_ACC2: begin
                    r_sat <= r_sat | w_acc_sat.clip;
                end
                S_UPD: begin
                    r_pos   <= w_pos_sat.val;
                    r_vel   <= w_vel_sat.val;
                    r_time  <= w_time_sat.val;
                    r_sat   <= r_sat | w_pos_sat.clip | w_vel_sat.clip | w_time_sat.clip;
                    r_phase <= r_phase + r_phase_step;
                    r_count <= r_count + STEP_COUNT_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_m_time <= r_time;
            r_m_pos  <= r_pos;
            r_m_vel  <= r_vel;
            r_m_sat  <= r_sat;
            r_m_last <= w_run_done;
            r_m_done <= r_done_item;
        end
    end

    assign o_s_axis_tready = w_ctl.in_ready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_vel, r_m_pos, r_m_time};
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tuser  = {r_m_done, r_m_sat};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_done_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_done) |-> (r_m_last && !r_m_sat))
        else $error("done report carries saturation or lacks last");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done0 == w_done1)
        else $error("multiplier units out of step");

    a_time_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_time[WORD_W-1])
        else $error("simulated time went negative");

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_restart && !w_run_done) |=> (r_state == S_MUL1 && !w_done0))
        else $error("step request did not start the multipliers");

endmodule
